// ===== sv/gsro_pkg.sv =====
// Shared types and constants for the Gram-Schmidt row orthonormalizer.
// Used by the lane, merge, square-root and top-level modules.
package gsro_pkg;

   localparam int E_W      = 16;  // input element / output element width
   localparam int PROD_W   = 32;  // basis * element
   localparam int P_W      = 35;  // projection sum over up to eight lanes
   localparam int PC_W     = 51;  // projection * basis
   localparam int C_W      = 56;  // correction accumulator
   localparam int R_W      = 31;  // residual, Q.12
   localparam int SQ_W     = 62;  // residual squared
   localparam int S_W      = 64;  // sum of squares
   localparam int ROOT_W   = 32;  // integer square root
   localparam int DIVN_W   = 46;  // dividend for the normalizing divide
   localparam int CNT_W    = 6;
   localparam int ROOT_STEPS = 32;
   localparam int DRAIN_CYC  = 4;
   localparam int DIV_STEPS  = 46;
   localparam int RES_SHIFT  = 18;
   localparam logic [R_W-1:0] RES_LIMIT = 31'h3FFF_FFFF;
   localparam logic signed [E_W-1:0] Q_MAX = 16'sh7FFF;
   localparam logic signed [E_W-1:0] Q_MIN = -16'sh8000;

   localparam logic [0:0] REG_ROWS = 1'b0;
   localparam logic [0:0] REG_COLS = 1'b1;

   typedef struct packed {
      logic load;      // capture a new row
      logic issue;     // read one stored basis row
      logic res_en;    // form the residual
      logic div_load;  // start the normalizing divide
      logic div_step;  // one quotient bit
      logic finish;    // write the basis and the output register
   } lane_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PROJ,
      ST_DRAIN,
      ST_RES,
      ST_SQ,
      ST_SUM,
      ST_ROOT,
      ST_DIV
   } state_type;

endpackage

// ===== sv/gsro_lane.sv =====
// One column lane: basis column memory, projection products, correction
// accumulator, residual, square and bit-serial normalizing divider. Uses gsro_pkg.
module gsro_lane #(
   parameter int LANE     = 0,
   parameter int MAX_ROWS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  gsro_pkg::lane_ctl_type                ctl,
   input  logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] rd_addr,
   input  logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] wr_addr,
   input  logic [3:0]                            cols_eff,
   input  logic signed [gsro_pkg::E_W-1:0]       e_in,
   input  logic signed [gsro_pkg::P_W-1:0]       p_in,
   input  logic [gsro_pkg::ROOT_W-1:0]           root,
   output logic signed [gsro_pkg::PROD_W-1:0]    prod_out,
   output logic [gsro_pkg::SQ_W-1:0]             sq_out,
   output logic signed [gsro_pkg::E_W-1:0]       q_out
);
   import gsro_pkg::*;

   logic active;
   logic signed [E_W-1:0] mem [MAX_ROWS];
   logic signed [E_W-1:0] x_ff, b_ff, b_d1_ff, b_d2_ff, q_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PC_W-1:0] pc_ff;
   logic signed [C_W-1:0] c_ff;
   logic [3:0] v_ff;
   logic signed [R_W-1:0] r_ff, r_in;
   logic [SQ_W-1:0] sq_ff;
   logic [DIVN_W-1:0] quo_ff, quo_in;
   logic [ROOT_W-1:0] rem_ff, rem_in;
   logic signed [E_W-1:0] q_in;

   logic signed [C_W:0] num;
   logic [C_W:0] mag, t_full;
   logic [R_W-1:0] t_sat, abs_r;
   logic [ROOT_W:0] trial;
   logic signed [2*R_W-1:0] sq_full;

   assign active = (4'(LANE) < cols_eff);

   // basis column store and the projection pipeline
   always_ff @(posedge clock) begin
      b_ff    <= mem[rd_addr];
      prod_ff <= b_ff * x_ff;
      b_d1_ff <= b_ff;
      b_d2_ff <= b_d1_ff;
      pc_ff   <= p_in * b_d2_ff;
      sq_ff   <= SQ_W'(sq_full);
      if (ctl.finish) begin
         mem[wr_addr] <= q_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[2:0], ctl.issue};
      end
   end

   // residual: round((x * 2^30 - c) / 2^18), ties away from zero, saturated
   always_comb begin
      num    = ((C_W+1)'(x_ff) <<< 30) - (C_W+1)'(c_ff);
      mag    = num[C_W] ? (C_W+1)'(-num) : (C_W+1)'(num);
      t_full = (mag + (C_W+1)'(1 << (RES_SHIFT - 1))) >> RES_SHIFT;
      t_sat  = (t_full > (C_W+1)'(RES_LIMIT)) ? RES_LIMIT : R_W'(t_full);
      if (!active) begin
         r_in = '0;
      end else if (num[C_W]) begin
         r_in = -$signed(t_sat);
      end else begin
         r_in = $signed(t_sat);
      end
      sq_full = r_ff * r_ff;
      abs_r   = r_ff[R_W-1] ? R_W'(-r_ff) : R_W'(r_ff);
   end

   // restoring divide, one quotient bit a cycle while div_step is set
   always_comb begin
      trial  = {rem_ff, quo_ff[DIVN_W-1]};
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (ctl.div_load) begin
         rem_in = '0;
         quo_in = (DIVN_W'(abs_r) << 15) + DIVN_W'(root >> 1);
      end else if (ctl.div_step) begin
         if (trial >= {1'b0, root}) begin
            rem_in = ROOT_W'(trial - {1'b0, root});
            quo_in = {quo_ff[DIVN_W-2:0], 1'b1};
         end else begin
            rem_in = ROOT_W'(trial);
            quo_in = {quo_ff[DIVN_W-2:0], 1'b0};
         end
      end
      if (root == '0) begin
         q_in = '0;
      end else if (!r_ff[R_W-1]) begin
         q_in = (quo_ff > DIVN_W'(32767)) ? Q_MAX : $signed(quo_ff[E_W-1:0]);
      end else begin
         q_in = (quo_ff > DIVN_W'(32768)) ? Q_MIN : -$signed(quo_ff[E_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         x_ff <= active ? e_in : '0;
         c_ff <= '0;
      end else if (v_ff[3]) begin
         c_ff <= c_ff + C_W'(pc_ff);
      end
      if (ctl.res_en) begin
         r_ff <= r_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (ctl.finish) begin
         q_ff <= q_in;
      end
   end

   assign prod_out = prod_ff;
   assign sq_out   = sq_ff;
   assign q_out    = q_ff;

endmodule

// ===== sv/gsro_merge.sv =====
// Merging stage: sums the lanes' projection products and squared residuals.
// Uses gsro_pkg.
module gsro_merge #(
   parameter int ROW_WIDTH = 8
) (
   input  logic                               clock,
   input  logic signed [gsro_pkg::PROD_W-1:0] prod [ROW_WIDTH],
   input  logic [gsro_pkg::SQ_W-1:0]          sq   [ROW_WIDTH],
   output logic signed [gsro_pkg::P_W-1:0]    p_sum,
   output logic [gsro_pkg::S_W-1:0]           s_sum
);
   import gsro_pkg::*;

   logic signed [P_W-1:0] p_ff, p_in;
   logic [S_W-1:0] s_ff, s_in;

   always_comb begin
      p_in = '0;
      s_in = '0;
      for (int j = 0; j < ROW_WIDTH; j++) begin
         p_in = p_in + P_W'(prod[j]);
         s_in = s_in + S_W'(sq[j]);
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
      s_ff <= s_in;
   end

   assign p_sum = p_ff;
   assign s_sum = s_ff;

endmodule

// ===== sv/gsro_isqrt.sv =====
// Integer square root of the sum of squares, one result bit per step,
// one step a cycle while step is set. Uses gsro_pkg.
module gsro_isqrt (
   input  logic                         clock,
   input  logic                         start,
   input  logic                         step,
   input  logic [gsro_pkg::S_W-1:0]     s_in,
   output logic [gsro_pkg::ROOT_W-1:0]  root
);
   import gsro_pkg::*;

   logic [S_W-1:0] rem_ff, rem_in, res_ff, res_in, bit_ff, bit_in;
   logic [S_W-1:0] trial;

   always_comb begin
      trial  = res_ff + bit_ff;
      rem_in = rem_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      if (start) begin
         rem_in = s_in;
         res_in = '0;
         bit_in = S_W'(1) << 62;
      end else if (step) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign root = res_ff[ROOT_W-1:0];

endmodule

// ===== sv/gram_schmidt_row_orthonormalizer_unit.sv =====
// Top level of the Gram-Schmidt row orthonormalizer: sequencer, CSRs, output
// register. Uses gsro_pkg, gsro_lane, gsro_merge and gsro_isqrt.
//
//   channel  direction  handshake                  payload
//   req      in         req_valid / req_stall      e0..e7
//   rsp      out        rsp_valid / rsp_stall      q0..q7, row_last, degenerate
//   csr      in/out     csr_psel/penable/pready    rows_in_use @0, cols_in_use @4
//
// Each row is accepted in idle and handled with one lane per column: for a row i > 0 the
// sequencer streams the i stored rows through the projection pipeline and drains it
// (row 0 skips both), then forms residual, square and sum, takes the square root,
// runs the divide and finish, and returns to idle to accept the next row.
// Reset clears the row index and sets both registers to 8; the basis store is
// not cleared. A stalled result holds in the output register while the next
// row is accepted; the block waits at the end of the divide until it is taken.
module gram_schmidt_row_orthonormalizer_unit #(
   parameter int MAX_ROWS  = 8,
   parameter int ROW_WIDTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic signed [15:0] req_e0,
   input  logic signed [15:0] req_e1,
   input  logic signed [15:0] req_e2,
   input  logic signed [15:0] req_e3,
   input  logic signed [15:0] req_e4,
   input  logic signed [15:0] req_e5,
   input  logic signed [15:0] req_e6,
   input  logic signed [15:0] req_e7,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [15:0] rsp_q0,
   output logic signed [15:0] rsp_q1,
   output logic signed [15:0] rsp_q2,
   output logic signed [15:0] rsp_q3,
   output logic signed [15:0] rsp_q4,
   output logic signed [15:0] rsp_q5,
   output logic signed [15:0] rsp_q6,
   output logic signed [15:0] rsp_q7,
   output logic        rsp_row_last,
   output logic        rsp_degenerate,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import gsro_pkg::*;

   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [RW-1:0] k_ff, k_in, cur_ff, cur_in, row_idx_ff, row_idx_in;
   logic last_ff, last_in;
   logic [3:0] rows_ff, cols_ff;
   logic rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_degen_ff;

   logic [7:0] rows_eff, start_row;
   logic [3:0] cols_eff;
   logic accept, rsp_free, csr_wr;
   lane_ctl_type ctl;
   logic root_start, root_step;

   logic signed [E_W-1:0] e_arr [8];
   logic signed [E_W-1:0] q_arr [8];
   logic signed [PROD_W-1:0] prod [ROW_WIDTH];
   logic [SQ_W-1:0] sq [ROW_WIDTH];
   logic signed [P_W-1:0] p_sum;
   logic [S_W-1:0] s_sum;
   logic [ROOT_W-1:0] root;

   assign e_arr[0] = req_e0;
   assign e_arr[1] = req_e1;
   assign e_arr[2] = req_e2;
   assign e_arr[3] = req_e3;
   assign e_arr[4] = req_e4;
   assign e_arr[5] = req_e5;
   assign e_arr[6] = req_e6;
   assign e_arr[7] = req_e7;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_COLS) ? {28'b0, cols_ff} : {28'b0, rows_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= 4'd8;
         cols_ff <= 4'd8;
      end else if (csr_wr) begin
         if (csr_paddr[2] == REG_ROWS) begin
            rows_ff <= csr_pwdata[3:0];
         end else begin
            cols_ff <= csr_pwdata[3:0];
         end
      end
   end

   always_comb begin
      rows_eff = {4'b0, rows_ff};
      if (rows_eff == 8'd0) begin
         rows_eff = 8'd1;
      end else if (rows_eff > 8'(MAX_ROWS)) begin
         rows_eff = 8'(MAX_ROWS);
      end
      cols_eff = cols_ff;
      if (cols_eff == 4'd0) begin
         cols_eff = 4'd1;
      end else if (cols_eff > 4'(ROW_WIDTH)) begin
         cols_eff = 4'(ROW_WIDTH);
      end
      // a lowered row count restarts the matrix
      start_row = (8'(row_idx_ff) >= rows_eff) ? 8'd0 : 8'(row_idx_ff);
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      cur_in       = cur_ff;
      last_in      = last_ff;
      row_idx_in   = row_idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ctl          = '0;
      root_start   = 1'b0;
      root_step    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ctl.load = 1'b1;
               cur_in   = RW'(start_row);
               last_in  = ((start_row + 8'd1) == rows_eff);
               k_in     = '0;
               state_in = (start_row == 8'd0) ? ST_RES : ST_PROJ;
            end
         end
         ST_PROJ: begin
            ctl.issue = 1'b1;
            if (k_ff == RW'(cur_ff - RW'(1))) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + RW'(1);
            end
         end
         ST_DRAIN: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DRAIN_CYC - 1)) begin
               state_in = ST_RES;
            end
         end
         ST_RES: begin
            ctl.res_en = 1'b1;
            state_in   = ST_SQ;
         end
         ST_SQ: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cnt_in   = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            root_start = (cnt_ff == '0);
            root_step  = (cnt_ff != '0);
            cnt_in     = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(ROOT_STEPS)) begin
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (cnt_ff == '0) begin
               ctl.div_load = 1'b1;
               cnt_in       = cnt_ff + CNT_W'(1);
            end else if (cnt_ff <= CNT_W'(DIV_STEPS)) begin
               ctl.div_step = 1'b1;
               cnt_in       = cnt_ff + CNT_W'(1);
            end else if (rsp_free) begin
               // hold here until the output register is free
               ctl.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               row_idx_in   = last_ff ? '0 : RW'(cur_ff + RW'(1));
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         k_ff         <= '0;
         cur_ff       <= '0;
         last_ff      <= 1'b0;
         row_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         k_ff         <= k_in;
         cur_ff       <= cur_in;
         last_ff      <= last_in;
         row_idx_ff   <= row_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.finish) begin
         rsp_last_ff  <= last_ff;
         rsp_degen_ff <= (root == '0);
      end
   end

   for (genvar j = 0; j < ROW_WIDTH; j++) begin : g_lane
      gsro_lane #(
         .LANE     (j),
         .MAX_ROWS (MAX_ROWS)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .rd_addr  (k_ff),
         .wr_addr  (cur_ff),
         .cols_eff (cols_eff),
         .e_in     (e_arr[j]),
         .p_in     (p_sum),
         .root     (root),
         .prod_out (prod[j]),
         .sq_out   (sq[j]),
         .q_out    (q_arr[j])
      );
   end

   for (genvar j = ROW_WIDTH; j < 8; j++) begin : g_zero
      assign q_arr[j] = '0;
   end

   gsro_merge #(
      .ROW_WIDTH (ROW_WIDTH)
   ) u_merge (
      .clock (clock),
      .prod  (prod),
      .sq    (sq),
      .p_sum (p_sum),
      .s_sum (s_sum)
   );

   gsro_isqrt u_isqrt (
      .clock (clock),
      .start (root_start),
      .step  (root_step),
      .s_in  (s_sum),
      .root  (root)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_row_last   = rsp_last_ff;
   assign rsp_degenerate = rsp_degen_ff;
   assign rsp_q0 = q_arr[0];
   assign rsp_q1 = q_arr[1];
   assign rsp_q2 = q_arr[2];
   assign rsp_q3 = q_arr[3];
   assign rsp_q4 = q_arr[4];
   assign rsp_q5 = q_arr[5];
   assign rsp_q6 = q_arr[6];
   assign rsp_q7 = q_arr[7];

endmodule
